### hw/rtl/fac_pkg.sv
// Package for the frustum box cull core: item types, plane layout and verdict codes.
package fac_pkg;

  localparam int CoordW   = 16;
  localparam int PlaneIdxW = 3;
  localparam int CfgDataW = 64;

  localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
  localparam logic [1:0] VERDICT_INSIDE  = 2'd1;
  localparam logic [1:0] VERDICT_OVERLAP = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic [PlaneIdxW-1:0]     start_plane;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           verdict;
    logic [PlaneIdxW-1:0] reject_plane;
  } out_item_t;

  // plane register layout, distance (offset) in the top 16 bits
  typedef struct packed {
    logic signed [CoordW-1:0] offset;
    logic signed [CoordW-1:0] nz;
    logic signed [CoordW-1:0] ny;
    logic signed [CoordW-1:0] nx;
  } plane_t;

endpackage

### hw/rtl/frustum_aabb_cull_core.sv
// Top level: pipelined classification of one box per item against the frustum planes.
//
//  channel | ports                         | moves
//  --------+-------------------------------+---------------------------------
//  input   | in_valid, in_stall, in_data   | one box and its start plane
//  result  | out_valid, out_stall, out_data| verdict and rejecting plane
//  config  | cfg_we, cfg_index, cfg_data   | one plane register per write
//
// Five register stages (sums, products, plane dot terms, compares, select);
// one item per cycle while the result side does not stall.
// Reset clears all valid bits and every plane register.
// A stall freezes only the occupied stages behind it; bubbles are filled.
module frustum_aabb_cull_core #(
  parameter int PLANE_COUNT = 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  fac_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output fac_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [fac_pkg::PlaneIdxW-1:0]      cfg_index,
  input  logic [fac_pkg::CfgDataW-1:0]       cfg_data
);

  localparam int SW = fac_pkg::CoordW + 1;  // sum and difference
  localparam int PW = 35;                   // single product
  localparam int DW = 37;                   // dot sums
  localparam int IW = fac_pkg::PlaneIdxW + 1;

  fac_pkg::plane_t plane_r [PLANE_COUNT];

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4, adv_out;

  logic signed [SW-1:0] sum_r [3];
  logic signed [SW-1:0] diff_r [3];
  logic [fac_pkg::PlaneIdxW-1:0] st1_r, st2_r, st3_r, st4_r;

  logic signed [PW-1:0] np_r [PLANE_COUNT][3];
  logic signed [PW-1:0] rp_r [PLANE_COUNT][3];
  logic signed [DW-1:0] d_r [PLANE_COUNT];
  logic signed [DW-1:0] r_r [PLANE_COUNT];
  logic [PLANE_COUNT-1:0] out_r, ovl_r;

  fac_pkg::out_item_t res_nxt;
  fac_pkg::out_item_t out_r_data;
  logic out_valid_r;

  assign adv_out  = !out_valid_r || !out_stall;
  assign adv4     = !v4_r || adv_out;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  assign out_valid = out_valid_r;
  assign out_data  = out_r_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        plane_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        if (cfg_we && cfg_index == fac_pkg::PlaneIdxW'(i)) begin
          plane_r[i] <= fac_pkg::plane_t'(cfg_data);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1)    v1_r        <= in_valid;
      if (adv2)    v2_r        <= v1_r;
      if (adv3)    v3_r        <= v2_r;
      if (adv4)    v4_r        <= v3_r;
      if (adv_out) out_valid_r <= v4_r;
    end
  end

  // stage 1: centre and extent, doubled
  always_ff @(posedge clk) begin
    if (adv1) begin
      sum_r[0]  <= SW'(in_data.max_x) + SW'(in_data.min_x);
      sum_r[1]  <= SW'(in_data.max_y) + SW'(in_data.min_y);
      sum_r[2]  <= SW'(in_data.max_z) + SW'(in_data.min_z);
      diff_r[0] <= SW'(in_data.max_x) - SW'(in_data.min_x);
      diff_r[1] <= SW'(in_data.max_y) - SW'(in_data.min_y);
      diff_r[2] <= SW'(in_data.max_z) - SW'(in_data.min_z);
      st1_r     <= in_data.start_plane;
    end
  end

  // stage 2: normal times centre, absolute normal times extent
  logic signed [fac_pkg::CoordW-1:0] ncomp [PLANE_COUNT][3];
  logic signed [SW-1:0]              nabs  [PLANE_COUNT][3];

  always_comb begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      ncomp[i][0] = plane_r[i].nx;
      ncomp[i][1] = plane_r[i].ny;
      ncomp[i][2] = plane_r[i].nz;
      for (int a = 0; a < 3; a++) begin
        nabs[i][a] = ncomp[i][a][fac_pkg::CoordW-1] ? -SW'(ncomp[i][a]) : SW'(ncomp[i][a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        for (int a = 0; a < 3; a++) begin
          np_r[i][a] <= PW'(ncomp[i][a]) * PW'(sum_r[a]);
          rp_r[i][a] <= PW'(nabs[i][a]) * PW'(diff_r[a]);
        end
      end
      st2_r <= st1_r;
    end
  end

  // stage 3: signed distance and projected radius
  always_ff @(posedge clk) begin
    if (adv3) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        d_r[i] <= DW'(np_r[i][0]) + DW'(np_r[i][1]) + DW'(np_r[i][2])
                  - (DW'(plane_r[i].offset) <<< 15);
        r_r[i] <= DW'(rp_r[i][0]) + DW'(rp_r[i][1]) + DW'(rp_r[i][2]);
      end
      st3_r <= st2_r;
    end
  end

  // stage 4: per-plane class
  always_ff @(posedge clk) begin
    if (adv4) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        out_r[i] <= d_r[i] < -r_r[i];
        ovl_r[i] <= !(d_r[i] < -r_r[i]) && !(d_r[i] > r_r[i]);
      end
      st4_r <= st3_r;
    end
  end

  // stage 5: first rejecting plane from the hint, with wrap-around
  logic [IW-1:0] start_eff;
  logic [IW-1:0] p;
  logic          found;
  logic          hit;
  logic [fac_pkg::PlaneIdxW-1:0] rej;

  always_comb begin
    start_eff = (IW'(st4_r) < IW'(PLANE_COUNT)) ? IW'(st4_r) : '0;
    found     = 1'b0;
    rej       = st4_r;
    p         = '0;
    hit       = 1'b0;
    for (int k = 0; k < PLANE_COUNT; k++) begin
      p = start_eff + IW'(k);
      if (p >= IW'(PLANE_COUNT)) p = p - IW'(PLANE_COUNT);
      hit = 1'b0;
      for (int j = 0; j < PLANE_COUNT; j++) begin
        if (p == IW'(j)) hit = out_r[j];
      end
      if (!found && hit) begin
        found = 1'b1;
        rej   = p[fac_pkg::PlaneIdxW-1:0];
      end
    end
    res_nxt.reject_plane = rej;
    if (found)       res_nxt.verdict = fac_pkg::VERDICT_OUTSIDE;
    else if (|ovl_r) res_nxt.verdict = fac_pkg::VERDICT_OVERLAP;
    else             res_nxt.verdict = fac_pkg::VERDICT_INSIDE;
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_r_data <= res_nxt;
    end
  end

endmodule

### hw/rtl/fac_checker.sv
// Port checker for the frustum box cull core, bound to the top level.
module fac_checker #(
  parameter int PLANE_COUNT = 6
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input fac_pkg::out_item_t            out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed under stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side free");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.verdict == fac_pkg::VERDICT_OUTSIDE
               || out_data.verdict == fac_pkg::VERDICT_INSIDE
               || out_data.verdict == fac_pkg::VERDICT_OVERLAP)
    else $error("bad verdict code");

  a_reject_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict == fac_pkg::VERDICT_OUTSIDE
      |-> 32'(out_data.reject_plane) < PLANE_COUNT)
    else $error("rejecting plane out of range");

endmodule

bind frustum_aabb_cull_core fac_checker #(.PLANE_COUNT(PLANE_COUNT)) u_fac_checker (.*);
